// ===== hdl/ckre_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ckre_pkg
// Shared types, constants and helpers of the color-key sprite run-length
// encoder.
// ----------------------------------------------------------------------------
package ckre_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;

	localparam int DIM_W   = 13;
	localparam int COL_W   = 12;
	localparam int CNT_W   = 13;
	localparam int BYTES_W = 15;
	localparam int PIX_W   = 32;
	localparam int ADDR_W  = 4;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// register indexes
	localparam logic [1:0] REG_FORMAT = 2'd0;
	localparam logic [1:0] REG_KEY    = 2'd1;
	localparam logic [1:0] REG_WIDTH  = 2'd2;
	localparam logic [1:0] REG_HEIGHT = 2'd3;

	// pixel formats
	localparam logic [1:0] FMT_8  = 2'd0;
	localparam logic [1:0] FMT_16 = 2'd1;
	localparam logic [1:0] FMT_24 = 2'd2;
	localparam logic [1:0] FMT_32 = 2'd3;

	localparam logic KIND_DATA  = 1'b0;
	localparam logic KIND_STRIP = 1'b1;

	typedef struct packed {
		logic [1:0]       pixel_format;
		logic [PIX_W-1:0] key_color;
		logic [DIM_W-1:0] image_width;
		logic [DIM_W-1:0] image_height;
	} cfg_t;

	// everything one pixel produces: closing strip, data word, row-end strip
	typedef struct packed {
		logic               close;
		logic [BYTES_W-1:0] close_run;
		logic [BYTES_W-1:0] close_skip;
		logic               data;
		logic [PIX_W-1:0]   pix;
		logic               row;
		logic [BYTES_W-1:0] row_run;
		logic [BYTES_W-1:0] row_skip;
		logic               frame;
	} entry_t;

	function automatic logic [PIX_W-1:0] fmt_mask(input logic [1:0] fmt);
		logic [PIX_W-1:0] m;
		case (fmt)
			FMT_8:   m = 32'h0000_00FF;
			FMT_16:  m = 32'h0000_FFFF;
			FMT_24:  m = 32'h00FF_FFFF;
			default: m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

	function automatic logic [BYTES_W-1:0] byte_len(input logic [CNT_W-1:0] cnt,
			input logic [1:0] fmt);
		logic [BYTES_W-1:0] b;
		case (fmt)
			FMT_8:   b = {2'b00, cnt};
			FMT_16:  b = {1'b0, cnt, 1'b0};
			default: b = {cnt, 2'b00};
		endcase
		return b;
	endfunction

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/ckre_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ckre_regs
// Configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
module ckre_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [ckre_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	output ckre_pkg::cfg_t                   cfg
);

	ckre_pkg::cfg_t cfg_q;
	logic           wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_format <= ckre_pkg::FMT_32;
			cfg_q.key_color    <= '0;
			cfg_q.image_width  <= ckre_pkg::DIM_W'(1);
			cfg_q.image_height <= ckre_pkg::DIM_W'(1);
		end else if (wr_en) begin
			case (paddr[3:2])
				ckre_pkg::REG_FORMAT: cfg_q.pixel_format <= pwdata[1:0];
				ckre_pkg::REG_KEY:    cfg_q.key_color    <= pwdata;
				ckre_pkg::REG_WIDTH:  cfg_q.image_width  <= pwdata[ckre_pkg::DIM_W-1:0];
				ckre_pkg::REG_HEIGHT: cfg_q.image_height <= pwdata[ckre_pkg::DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			ckre_pkg::REG_FORMAT: prdata = {30'd0, cfg_q.pixel_format};
			ckre_pkg::REG_KEY:    prdata = cfg_q.key_color;
			ckre_pkg::REG_WIDTH:  prdata = {19'd0, cfg_q.image_width};
			ckre_pkg::REG_HEIGHT: prdata = {19'd0, cfg_q.image_height};
			default:              prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ===== hdl/ckre_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ckre_front
// Accepts pixels, applies the color key, keeps the run and raster counters
// and builds one queue entry per pixel that produces output.
// ----------------------------------------------------------------------------
module ckre_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire ckre_pkg::cfg_t             cfg,
	input  wire logic                       pix_valid,
	output logic                            pix_ready,
	input  wire logic [ckre_pkg::PIX_W-1:0] pixel_value,
	input  wire logic                       queue_full,
	output logic                            push,
	output ckre_pkg::entry_t                push_entry
);

	logic [ckre_pkg::CNT_W-1:0] opaque_q, skip_q;
	logic                       in_skip_q;
	logic [ckre_pkg::COL_W-1:0] col_q, row_q;

	logic                       accept;
	logic [ckre_pkg::PIX_W-1:0] pix;
	logic                       transparent;
	logic                       close;
	logic [ckre_pkg::CNT_W-1:0] opaque_base, skip_base, opaque_n, skip_n;
	logic [ckre_pkg::DIM_W-1:0] w, h, col_next, row_next;
	logic                       row_end, frame_end;

	assign pix_ready = !queue_full;
	assign accept    = pix_valid && pix_ready;

	always_comb begin
		w           = ckre_pkg::clamp_dim(cfg.image_width, ckre_pkg::DIM_W'(ckre_pkg::MAX_WIDTH));
		h           = ckre_pkg::clamp_dim(cfg.image_height,
			ckre_pkg::DIM_W'(ckre_pkg::MAX_HEIGHT));
		pix         = pixel_value & ckre_pkg::fmt_mask(cfg.pixel_format);
		transparent = (pix == cfg.key_color);
		close       = !transparent && in_skip_q;
		opaque_base = close ? '0 : opaque_q;
		skip_base   = close ? '0 : skip_q;
		opaque_n    = transparent ? opaque_base : opaque_base + ckre_pkg::CNT_W'(1);
		skip_n      = transparent ? skip_base + ckre_pkg::CNT_W'(1) : skip_base;
		col_next    = {1'b0, col_q} + ckre_pkg::DIM_W'(1);
		row_next    = {1'b0, row_q} + ckre_pkg::DIM_W'(1);
		row_end     = (col_next >= w);
		frame_end   = (row_next >= h);

		push_entry.close      = close;
		push_entry.close_run  = ckre_pkg::byte_len(opaque_q, cfg.pixel_format);
		push_entry.close_skip = ckre_pkg::byte_len(skip_q, cfg.pixel_format);
		push_entry.data       = !transparent;
		push_entry.pix        = pix;
		push_entry.row        = row_end;
		push_entry.row_run    = ckre_pkg::byte_len(opaque_n, cfg.pixel_format);
		push_entry.row_skip   = ckre_pkg::byte_len(skip_n, cfg.pixel_format);
		push_entry.frame      = frame_end;
	end

	// a transparent pixel inside a row produces nothing
	assign push = accept && (!transparent || row_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opaque_q  <= '0;
			skip_q    <= '0;
			in_skip_q <= 1'b0;
			col_q     <= '0;
			row_q     <= '0;
		end else if (accept) begin
			if (row_end) begin
				opaque_q  <= '0;
				skip_q    <= '0;
				in_skip_q <= 1'b0;
				col_q     <= '0;
				row_q     <= frame_end ? '0 : row_next[ckre_pkg::COL_W-1:0];
			end else begin
				opaque_q  <= opaque_n;
				skip_q    <= skip_n;
				in_skip_q <= transparent;
				col_q     <= col_next[ckre_pkg::COL_W-1:0];
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/ckre_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ckre_queue
// Short register queue of entries between the front and the back.
// ----------------------------------------------------------------------------
module ckre_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire ckre_pkg::entry_t push_entry,
	output logic                  full,
	output logic                  head_valid,
	output ckre_pkg::entry_t      head,
	input  wire logic             pop
);

	ckre_pkg::entry_t               slots_q [ckre_pkg::QUEUE_DEPTH];
	logic [ckre_pkg::QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [ckre_pkg::QCNT_W-1:0]    count_q;

	assign full       = (count_q == ckre_pkg::QCNT_W'(ckre_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + ckre_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + ckre_pkg::QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + ckre_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - ckre_pkg::QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hdl/ckre_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ckre_back
// Expands each queue entry into its output words, one word per cycle while
// the receiver is ready, through an output register.
// ----------------------------------------------------------------------------
module ckre_back (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           head_valid,
	input  wire ckre_pkg::entry_t               head,
	output logic                                pop,
	output logic                                rec_valid,
	input  wire logic                           rec_ready,
	output logic                                record_kind,
	output logic [ckre_pkg::PIX_W-1:0]          pixel_out,
	output logic [ckre_pkg::BYTES_W-1:0]        run_bytes,
	output logic [ckre_pkg::BYTES_W-1:0]        skip_bytes,
	output logic                                row_done,
	output logic                                frame_done,
	output logic                                last
);

	logic                         valid_q;
	logic                         sent_close_q, sent_data_q;
	logic                         kind_q, row_done_q, frame_done_q, last_q;
	logic [ckre_pkg::PIX_W-1:0]   pix_q;
	logic [ckre_pkg::BYTES_W-1:0] run_q, skip_q;

	logic                         load, sel_close, sel_data, is_last;

	always_comb begin
		sel_close = head.close && !sent_close_q;
		sel_data  = !sel_close && head.data && !sent_data_q;
		if (sel_close) begin
			is_last = !(head.data || head.row);
		end else if (sel_data) begin
			is_last = !head.row;
		end else begin
			is_last = 1'b1;
		end
	end

	assign load = head_valid && (!valid_q || rec_ready);
	assign pop  = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= 1'b0;
			sent_close_q <= 1'b0;
			sent_data_q  <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
			end else if (rec_ready) begin
				valid_q <= 1'b0;
			end
			if (load) begin
				if (is_last) begin
					sent_close_q <= 1'b0;
					sent_data_q  <= 1'b0;
				end else if (sel_close) begin
					sent_close_q <= 1'b1;
				end else begin
					sent_data_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			last_q <= is_last;
			if (sel_close) begin
				kind_q       <= ckre_pkg::KIND_STRIP;
				pix_q        <= '0;
				run_q        <= head.close_run;
				skip_q       <= head.close_skip;
				row_done_q   <= 1'b0;
				frame_done_q <= 1'b0;
			end else if (sel_data) begin
				kind_q       <= ckre_pkg::KIND_DATA;
				pix_q        <= head.pix;
				run_q        <= '0;
				skip_q       <= '0;
				row_done_q   <= 1'b0;
				frame_done_q <= 1'b0;
			end else begin
				kind_q       <= ckre_pkg::KIND_STRIP;
				pix_q        <= '0;
				run_q        <= head.row_run;
				skip_q       <= head.row_skip;
				row_done_q   <= 1'b1;
				frame_done_q <= head.frame;
			end
		end
	end

	assign rec_valid   = valid_q;
	assign record_kind = kind_q;
	assign pixel_out   = pix_q;
	assign run_bytes   = run_q;
	assign skip_bytes  = skip_q;
	assign row_done    = row_done_q;
	assign frame_done  = frame_done_q;
	assign last        = last_q;

endmodule
`default_nettype wire

// ===== hdl/color_key_sprite_rle_encoder_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// color_key_sprite_rle_encoder_top
// Color-key sprite run-length encoder.
//
// Pixels enter in raster order on pix_valid/pix_ready with pixel_value.
// Each pixel yields zero to three output words on rec_valid/rec_ready:
// a strip record closing the previous strip, the opaque pixel data word,
// and a row-end strip record; last marks the final word of a pixel.
// Words leave one per cycle while the receiver is ready; a pixel has
// one word when it is opaque inside a strip, up to three when it also
// closes a strip and ends the row; transparent pixels inside a row
// yield no word and are taken one per cycle while the queue is not full.
// The first word of a pixel goes through a queue slot, then the output register.
// The rate is set by the single output register of the word expander.
// A four-entry queue sits between classifier and expander; when the
// receiver stalls, the queue fills and pix_ready drops while full.
// Configuration goes through the APB-style port; write it only while idle.
// Reset restores 32-bit format, key 0, width and height 1, and clears the
// run and raster counters, the queue and the output valid flag.
// ----------------------------------------------------------------------------
module color_key_sprite_rle_encoder_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [ckre_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	input  wire logic                          pix_valid,
	output logic                               pix_ready,
	input  wire logic [ckre_pkg::PIX_W-1:0]    pixel_value,
	output logic                               rec_valid,
	input  wire logic                          rec_ready,
	output logic                               record_kind,
	output logic [ckre_pkg::PIX_W-1:0]         pixel_out,
	output logic [ckre_pkg::BYTES_W-1:0]       run_bytes,
	output logic [ckre_pkg::BYTES_W-1:0]       skip_bytes,
	output logic                               row_done,
	output logic                               frame_done,
	output logic                               last
);

	ckre_pkg::cfg_t   cfg;
	ckre_pkg::entry_t push_entry, head;
	logic             push, pop, queue_full, head_valid;

	ckre_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ckre_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.pix_valid   (pix_valid),
		.pix_ready   (pix_ready),
		.pixel_value (pixel_value),
		.queue_full  (queue_full),
		.push        (push),
		.push_entry  (push_entry)
	);

	ckre_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	ckre_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.rec_valid   (rec_valid),
		.rec_ready   (rec_ready),
		.record_kind (record_kind),
		.pixel_out   (pixel_out),
		.run_bytes   (run_bytes),
		.skip_bytes  (skip_bytes),
		.row_done    (row_done),
		.frame_done  (frame_done),
		.last        (last)
	);

endmodule
`default_nettype wire

// ===== sim/tb_color_key_sprite_rle_encoder_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_color_key_sprite_rle_encoder_top
// Self-checking bench for the color-key sprite run-length encoder. A short
// table of register writes and pixels runs first. Random phases follow, each
// with its own format, key and raster size. In one phase the receiver holds
// off so that the pixel input backs up. A short run under an oversized
// raster, closed by narrowing the width, ends the run.
// Output words are checked against table words where given, else an encoder model.
// ----------------------------------------------------------------------------
module tb_color_key_sprite_rle_encoder_top;

	localparam int RANDOM_ITEMS  = 370;
	localparam int SETTLE_CYCLES = 16;
	localparam int DRAIN_LIMIT   = 50000;
	localparam int HOLD_CYCLES   = 300;

	typedef struct packed {
		logic                         kind;
		logic [ckre_pkg::PIX_W-1:0]   pix;
		logic [ckre_pkg::BYTES_W-1:0] run;
		logic [ckre_pkg::BYTES_W-1:0] skip;
		logic                         row_end;
		logic                         frame_end;
		logic                         last_word;
	} enc_word_t;

	typedef enum int {ROW_CFG, ROW_PIX} row_op_t;

	typedef struct {
		row_op_t     op;
		logic [1:0]  reg_idx;
		logic [31:0] value;
		int          n_typed;
		enc_word_t   w0;
		enc_word_t   w1;
	} dir_row_t;

	localparam enc_word_t NO_WORD = '0;

	logic                         clk;
	logic                         arst_n;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [ckre_pkg::ADDR_W-1:0]  paddr;
	logic [31:0]                  pwdata;
	logic [31:0]                  prdata;
	logic                         pready;
	logic                         pix_valid;
	logic                         pix_ready;
	logic [ckre_pkg::PIX_W-1:0]   pixel_value;
	logic                         rec_valid;
	logic                         rec_ready;
	logic                         record_kind;
	logic [ckre_pkg::PIX_W-1:0]   pixel_out;
	logic [ckre_pkg::BYTES_W-1:0] run_bytes;
	logic [ckre_pkg::BYTES_W-1:0] skip_bytes;
	logic                         row_done;
	logic                         frame_done;
	logic                         last;

	// encoder model state
	logic [1:0]                 cfg_format = ckre_pkg::FMT_32;
	logic [ckre_pkg::PIX_W-1:0] cfg_key    = '0;
	logic [ckre_pkg::DIM_W-1:0] cfg_width  = ckre_pkg::DIM_W'(1);
	logic [ckre_pkg::DIM_W-1:0] cfg_height = ckre_pkg::DIM_W'(1);
	int                         opaque_cnt = 0;
	int                         skip_cnt   = 0;
	bit                         in_skip    = 1'b0;
	int                         col_idx    = 0;
	int                         row_idx    = 0;

	enc_word_t pred_words [3];
	int        pred_n;
	enc_word_t expected_words [$];

	int fails     = 0;
	bit quiet     = 1'b0;
	int hold_left = 0;

	dir_row_t dir_tab [25] = '{
		'{ROW_PIX, ckre_pkg::REG_FORMAT, 32'h0000_0000, 1,
			'{ckre_pkg::KIND_STRIP, 32'h0, 15'd0, 15'd4, 1'b1, 1'b1, 1'b1}, NO_WORD},
		'{ROW_PIX, ckre_pkg::REG_FORMAT, 32'hFFFF_FFFF, 2,
			'{ckre_pkg::KIND_DATA, 32'hFFFF_FFFF, 15'd0, 15'd0, 1'b0, 1'b0, 1'b0},
			'{ckre_pkg::KIND_STRIP, 32'h0, 15'd4, 15'd0, 1'b1, 1'b1, 1'b1}},
		'{ROW_CFG, ckre_pkg::REG_FORMAT, 32'(ckre_pkg::FMT_8), 0, NO_WORD, NO_WORD},
		'{ROW_CFG, ckre_pkg::REG_KEY, 32'h0000_0012, 0, NO_WORD, NO_WORD},
		'{ROW_PIX, ckre_pkg::REG_FORMAT, 32'hABCD_EF12, 1,
			'{ckre_pkg::KIND_STRIP, 32'h0, 15'd0, 15'd1, 1'b1, 1'b1, 1'b1}, NO_WORD},
		'{ROW_PIX, ckre_pkg::REG_FORMAT, 32'h0000_00FF, 2,
			'{ckre_pkg::KIND_DATA, 32'h0000_00FF, 15'd0, 15'd0, 1'b0, 1'b0, 1'b0},
			'{ckre_pkg::KIND_STRIP, 32'h0, 15'd1, 15'd0, 1'b1, 1'b1, 1'b1}},
		'{ROW_CFG, ckre_pkg::REG_KEY, 32'h0000_0112, 0, NO_WORD, NO_WORD},
		'{ROW_PIX, ckre_pkg::REG_FORMAT, 32'h0000_0112, 2,
			'{ckre_pkg::KIND_DATA, 32'h0000_0012, 15'd0, 15'd0, 1'b0, 1'b0, 1'b0},
			'{ckre_pkg::KIND_STRIP, 32'h0, 15'd1, 15'd0, 1'b1, 1'b1, 1'b1}},
		'{ROW_CFG, ckre_pkg::REG_FORMAT, 32'(ckre_pkg::FMT_16), 0, NO_WORD, NO_WORD},
		'{ROW_CFG, ckre_pkg::REG_KEY, 32'h0000_1234, 0, NO_WORD, NO_WORD},
		'{ROW_CFG, ckre_pkg::REG_WIDTH, 32'd6, 0, NO_WORD, NO_WORD},
		'{ROW_CFG, ckre_pkg::REG_HEIGHT, 32'd0, 0, NO_WORD, NO_WORD},
		'{ROW_PIX, ckre_pkg::REG_FORMAT, 32'h0000_5555, 0, NO_WORD, NO_WORD},
		'{ROW_PIX, ckre_pkg::REG_FORMAT, 32'hFFFF_1234, 0, NO_WORD, NO_WORD},
		'{ROW_PIX, ckre_pkg::REG_FORMAT, 32'h0000_1234, 0, NO_WORD, NO_WORD},
		'{ROW_PIX, ckre_pkg::REG_FORMAT, 32'h0000_0001, 0, NO_WORD, NO_WORD},
		'{ROW_PIX, ckre_pkg::REG_FORMAT, 32'h8000_1234, 0, NO_WORD, NO_WORD},
		'{ROW_CFG, ckre_pkg::REG_WIDTH, 32'd2, 0, NO_WORD, NO_WORD},
		'{ROW_PIX, ckre_pkg::REG_FORMAT, 32'h0000_1234, 0, NO_WORD, NO_WORD},
		'{ROW_CFG, ckre_pkg::REG_FORMAT, 32'(ckre_pkg::FMT_24), 0, NO_WORD, NO_WORD},
		'{ROW_CFG, ckre_pkg::REG_KEY, 32'h00FF_0000, 0, NO_WORD, NO_WORD},
		'{ROW_CFG, ckre_pkg::REG_WIDTH, 32'd0, 0, NO_WORD, NO_WORD},
		'{ROW_PIX, ckre_pkg::REG_FORMAT, 32'hAAFF_0000, 1,
			'{ckre_pkg::KIND_STRIP, 32'h0, 15'd0, 15'd4, 1'b1, 1'b1, 1'b1}, NO_WORD},
		'{ROW_PIX, ckre_pkg::REG_FORMAT, 32'h8012_3456, 2,
			'{ckre_pkg::KIND_DATA, 32'h0012_3456, 15'd0, 15'd0, 1'b0, 1'b0, 1'b0},
			'{ckre_pkg::KIND_STRIP, 32'h0, 15'd4, 15'd0, 1'b1, 1'b1, 1'b1}},
		'{ROW_PIX, ckre_pkg::REG_FORMAT, 32'h7F00_0000, 0, NO_WORD, NO_WORD}
	};

	color_key_sprite_rle_encoder_top u_dut (.*);

	function automatic logic [31:0] pixel_mask(input logic [1:0] fmt);
		return 32'hFFFF_FFFF >> (8 * (3 - int'(fmt)));
	endfunction

	function automatic int pixel_bytes(input logic [1:0] fmt);
		if (fmt == ckre_pkg::FMT_8) return 1;
		if (fmt == ckre_pkg::FMT_16) return 2;
		return 4;
	endfunction

	function automatic logic [ckre_pkg::BYTES_W-1:0] count_to_bytes(input int count);
		int b;
		b = count * pixel_bytes(cfg_format);
		if (b > 'h7FFF) b = 'h7FFF;
		return ckre_pkg::BYTES_W'(b);
	endfunction

	function automatic int eff_dim(input logic [ckre_pkg::DIM_W-1:0] v, input int maxv);
		if (v == '0) return 1;
		if (int'(v) > maxv) return maxv;
		return int'(v);
	endfunction

	function automatic enc_word_t strip_word(input int op_cnt, input int sk_cnt,
			input logic rd, input logic fd);
		enc_word_t w;
		w = '0;
		w.kind = ckre_pkg::KIND_STRIP;
		w.run = count_to_bytes(op_cnt);
		w.skip = count_to_bytes(sk_cnt);
		w.row_end = rd;
		w.frame_end = fd;
		return w;
	endfunction

	function automatic void encode_pixel(input logic [ckre_pkg::PIX_W-1:0] v);
		int w;
		int h;
		logic [ckre_pkg::PIX_W-1:0] pix;
		logic frame_end;
		w = eff_dim(cfg_width, ckre_pkg::MAX_WIDTH);
		h = eff_dim(cfg_height, ckre_pkg::MAX_HEIGHT);
		pix = v & pixel_mask(cfg_format);
		pred_n = 0;
		if (pix == cfg_key) begin
			in_skip = 1'b1;
			if (skip_cnt < 'hFFFF) skip_cnt++;
		end else begin
			if (in_skip) begin
				pred_words[pred_n] = strip_word(opaque_cnt, skip_cnt, 1'b0, 1'b0);
				pred_n++;
				opaque_cnt = 0;
				skip_cnt = 0;
				in_skip = 1'b0;
			end
			pred_words[pred_n] = '0;
			pred_words[pred_n].kind = ckre_pkg::KIND_DATA;
			pred_words[pred_n].pix = pix;
			pred_n++;
			if (opaque_cnt < 'hFFFF) opaque_cnt++;
		end
		if (col_idx + 1 >= w) begin
			frame_end = (row_idx + 1 >= h);
			pred_words[pred_n] = strip_word(opaque_cnt, skip_cnt, 1'b1, frame_end);
			pred_n++;
			opaque_cnt = 0;
			skip_cnt = 0;
			in_skip = 1'b0;
			col_idx = 0;
			row_idx = frame_end ? 0 : row_idx + 1;
		end else begin
			col_idx++;
		end
		if (pred_n > 0) pred_words[pred_n - 1].last_word = 1'b1;
	endfunction

	function automatic void apply_reg(input logic [1:0] idx, input logic [31:0] value);
		case (idx)
			ckre_pkg::REG_FORMAT: cfg_format = value[1:0];
			ckre_pkg::REG_KEY:    cfg_key = value;
			ckre_pkg::REG_WIDTH:  cfg_width = value[ckre_pkg::DIM_W-1:0];
			ckre_pkg::REG_HEIGHT: cfg_height = value[ckre_pkg::DIM_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fails++;
		end
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ckre_pkg::ADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		apply_reg(idx, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic send_pixel(input logic [ckre_pkg::PIX_W-1:0] v, input int gap,
			input int n_typed, input enc_word_t w0, input enc_word_t w1);
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_valid <= 1'b1;
		pixel_value <= v;
		do @(posedge clk); while (!pix_ready);
		encode_pixel(v);
		if (n_typed == 0) begin
			for (int k = 0; k < pred_n; k++) expected_words.push_back(pred_words[k]);
		end else begin
			expected_words.push_back(w0);
			if (n_typed > 1) expected_words.push_back(w1);
		end
		@(negedge clk);
	endtask

	task automatic wait_drained();
		int n;
		n = 0;
		while (expected_words.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		if (expected_words.size() != 0) begin
			$error("%0d expected words never arrived", expected_words.size());
			fails++;
			expected_words.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_mode(input bit q, input int hold);
		@(posedge clk);
		quiet = q;
		hold_left = hold;
		@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("tb_color_key_sprite_rle_encoder_top: FAIL");
		$finish;
	end

	// receiver
	initial begin
		int stall;
		stall = 0;
		rec_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				rec_ready <= 1'b0;
				hold_left--;
			end else if (stall > 0) begin
				rec_ready <= 1'b0;
				stall--;
			end else begin
				rec_ready <= 1'b1;
				if (!quiet && $urandom_range(0, 3) == 0) stall = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		enc_word_t want;
		if (arst_n && rec_valid && rec_ready) begin
			if (expected_words.size() == 0) begin
				$error("unexpected word: kind %0d pixel %h run %0d skip %0d",
					record_kind, pixel_out, run_bytes, skip_bytes);
				fails++;
			end else begin
				want = expected_words.pop_front();
				check_field("record_kind", 32'(want.kind), 32'(record_kind));
				check_field("pixel_out", want.pix, pixel_out);
				check_field("run_bytes", 32'(want.run), 32'(run_bytes));
				check_field("skip_bytes", 32'(want.skip), 32'(skip_bytes));
				check_field("row_done", 32'(want.row_end), 32'(row_done));
				check_field("frame_done", 32'(want.frame_end), 32'(frame_done));
				check_field("last", 32'(want.last_word), 32'(last));
			end
		end
	end

	initial begin
		logic [31:0] pal [4];
		logic [31:0] mask;
		logic [31:0] v;
		logic [31:0] w_val;
		logic [31:0] h_val;
		logic [1:0]  fmt;
		int n_items;
		int cls;
		int r;
		bit gap_on;
		int random_items;
		int phase;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pix_valid = 1'b0;
		pixel_value = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].op == ROW_CFG) begin
				if (pix_valid) begin
					pix_valid <= 1'b0;
					wait_drained();
				end
				write_reg(dir_tab[i].reg_idx, dir_tab[i].value);
			end else begin
				send_pixel(dir_tab[i].value, pick_gap(), dir_tab[i].n_typed,
					dir_tab[i].w0, dir_tab[i].w1);
			end
		end
		pix_valid <= 1'b0;
		wait_drained();

		random_items = 0;
		phase = 0;
		while (random_items < RANDOM_ITEMS) begin
			fmt = 2'($urandom_range(0, 3));
			mask = pixel_mask(fmt);
			r = $urandom_range(0, 9);
			w_val = (r == 0) ? 0 : (r == 9) ? $urandom_range(9, 24) : $urandom_range(1, 8);
			r = $urandom_range(0, 9);
			h_val = (r == 0) ? 0 :
				(r == 9) ? $urandom_range(ckre_pkg::MAX_HEIGHT + 1, 8191) :
				$urandom_range(1, 4);
			for (int k = 1; k < 4; k++) pal[k] = $urandom() & mask;
			if (fmt != ckre_pkg::FMT_32 && $urandom_range(0, 7) == 0) begin
				pal[0] = $urandom() | ~mask;
			end else begin
				pal[0] = $urandom() & mask;
			end
			write_reg(ckre_pkg::REG_FORMAT, ($urandom() & ~32'h3) | 32'(fmt));
			write_reg(ckre_pkg::REG_KEY, pal[0]);
			write_reg(ckre_pkg::REG_WIDTH, ($urandom() & ~32'h1FFF) | w_val);
			write_reg(ckre_pkg::REG_HEIGHT, ($urandom() & ~32'h1FFF) | h_val);

			if (phase == 2) begin
				set_mode(1'b0, HOLD_CYCLES);
				gap_on = 1'b0;
				n_items = 40;
			end else begin
				set_mode(phase % 4 == 3, 0);
				gap_on = (phase % 4 != 3);
				n_items = $urandom_range(10, 40);
			end

			cls = 0;
			for (int k = 0; k < n_items; k++) begin
				if ($urandom_range(0, 9) < 3) cls = $urandom_range(0, 9);
				if (cls < 4) begin
					v = ($urandom() & ~mask) | (pal[0] & mask);
				end else if (cls < 8) begin
					v = ($urandom() & ~mask) | pal[1 + cls % 3];
				end else if (cls == 8) begin
					v = $urandom();
				end else begin
					v = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0;
				end
				send_pixel(v, gap_on ? pick_gap() : 0, 0, NO_WORD, NO_WORD);
			end
			random_items += n_items;
			pix_valid <= 1'b0;
			wait_drained();
			phase++;
		end

		// realign to column 0, then a run under an oversized raster closed by a narrow width
		set_mode(1'b1, 0);
		write_reg(ckre_pkg::REG_FORMAT, 32'(ckre_pkg::FMT_32));
		write_reg(ckre_pkg::REG_KEY, 32'h0);
		write_reg(ckre_pkg::REG_WIDTH, 32'd1);
		write_reg(ckre_pkg::REG_HEIGHT, 32'd1);
		send_pixel($urandom(), 0, 0, NO_WORD, NO_WORD);
		pix_valid <= 1'b0;
		wait_drained();
		write_reg(ckre_pkg::REG_WIDTH, 32'h1FFF);
		write_reg(ckre_pkg::REG_HEIGHT, 32'h1FFF);
		for (int k = 0; k < 12; k++) begin
			send_pixel($urandom() | 32'h1, 0, 0, NO_WORD, NO_WORD);
		end
		for (int k = 0; k < 12; k++) begin
			send_pixel(32'h0, 0, 0, NO_WORD, NO_WORD);
		end
		pix_valid <= 1'b0;
		wait_drained();
		write_reg(ckre_pkg::REG_WIDTH, 32'd1);
		send_pixel(32'h0, 0, 0, NO_WORD, NO_WORD);
		pix_valid <= 1'b0;
		wait_drained();

		if (fails == 0) begin
			$display("tb_color_key_sprite_rle_encoder_top: PASS");
		end else begin
			$display("tb_color_key_sprite_rle_encoder_top: FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire
